FILE: rtl/yv12_pkg.sv
// ---------------------------------------------------------------------------
// yv12_pkg
// Shared sizes, codes, types and the frame dimension clamp used by the
// YUYV to YV12 chroma subsampling block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yv12_pkg;

  // Frame limits and derived sizes
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int DIM_W      = 12;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LUMA_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CHROMA_W   = LUMA_W - 2;
  localparam int AREA_W     = LUMA_W + 1;
  localparam int ADDR_W     = 23;
  localparam int BYTE_W     = 8;
  localparam int PLANE_W    = 2;
  localparam int IDX_W      = 2;
  localparam int LINE_DW    = 2 * BYTE_W;

  // Smallest legal dimension, and the shift that gives a quarter plane
  localparam logic [DIM_W-1:0] MIN_DIM     = DIM_W'(2);
  localparam int               QUARTER_SHIFT = 2;

  localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd2;

  // Frame geometry as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [AREA_W-1:0] area;
    logic              restart;
  } cfg_t;

  // Frame position of one macropixel
  typedef struct packed {
    logic [LUMA_W-1:0]   luma;
    logic [CHROMA_W-1:0] chroma;
    logic [LINE_AW-1:0]  col;
    logic                odd;
  } pos_t;

  // One accepted macropixel with its position
  typedef struct packed {
    logic [BYTE_W-1:0] y0;
    logic [BYTE_W-1:0] u;
    logic [BYTE_W-1:0] y1;
    logic [BYTE_W-1:0] v;
    pos_t              pos;
  } item_t;

  // Clamp a written dimension to [2, maxv] and round down to even
  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] val,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = val;
    if (r < MIN_DIM) begin
      r = MIN_DIM;
    end
    if (r > maxv) begin
      r = maxv;
    end
    r[0] = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/yv12_ram.sv
// ---------------------------------------------------------------------------
// yv12_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yv12_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/yv12_cfg.sv
// ---------------------------------------------------------------------------
// yv12_cfg
// Frame width and height registers with clamping, and the registered
// luma plane area used to place the chroma planes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yv12_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_enable,
  input  wire logic [yv12_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [yv12_pkg::DIM_W-1:0]    cfg_write_data,
  output      yv12_pkg::cfg_t                cfg
);

  logic [yv12_pkg::DIM_W-1:0]    width_r,  width_nxt;
  logic [yv12_pkg::DIM_W-1:0]    height_r, height_nxt;
  logic [yv12_pkg::AREA_W-1:0]   area_r;
  logic [2*yv12_pkg::DIM_W-1:0]  area_full;
  logic                          wr_width;
  logic                          wr_height;

  assign wr_width  = cfg_write_enable && (cfg_index == yv12_pkg::REG_FRAME_WIDTH);
  assign wr_height = cfg_write_enable && (cfg_index == yv12_pkg::REG_FRAME_HEIGHT);

  // Clamp written values
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_width) begin
      width_nxt = yv12_pkg::fit_dim(cfg_write_data, yv12_pkg::MAX_WIDTH_DIM);
    end
    if (wr_height) begin
      height_nxt = yv12_pkg::fit_dim(cfg_write_data, yv12_pkg::MAX_HEIGHT_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= yv12_pkg::fit_dim(12'd640, yv12_pkg::MAX_WIDTH_DIM);
      height_r <= yv12_pkg::fit_dim(12'd480, yv12_pkg::MAX_HEIGHT_DIM);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Register the plane area from the current dimensions
  assign area_full = width_r * height_r;

  always_ff @(posedge clk) begin
    area_r <= area_full[yv12_pkg::AREA_W-1:0];
  end

  assign cfg.width   = width_r;
  assign cfg.height  = height_r;
  assign cfg.area    = area_r;
  assign cfg.restart = wr_width || wr_height;

endmodule

`default_nettype wire

FILE: rtl/yv12_ctr.sv
// ---------------------------------------------------------------------------
// yv12_ctr
// Frame position counters: macropixel column, row, luma address and
// chroma index, advanced once per accepted item and wrapped at frame end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yv12_ctr (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire yv12_pkg::cfg_t  cfg,
  input  wire logic            advance,
  output      yv12_pkg::pos_t  pos
);

  logic [yv12_pkg::LINE_AW-1:0]  col_r,    col_nxt;
  logic [yv12_pkg::ROW_W-1:0]    row_r,    row_nxt;
  logic [yv12_pkg::LUMA_W-1:0]   luma_r,   luma_nxt;
  logic [yv12_pkg::CHROMA_W-1:0] chroma_r, chroma_nxt;
  logic [yv12_pkg::LINE_AW:0]    pairs;
  logic                          col_last;
  logic                          row_last;

  assign pairs    = cfg.width[yv12_pkg::DIM_W-1:1];
  assign col_last = ({1'b0, col_r} + 1'b1) == pairs;
  assign row_last = ({1'b0, row_r} + 1'b1) == cfg.height;

  // Advance position; restart on any dimension write or at frame end
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    luma_nxt   = luma_r;
    chroma_nxt = chroma_r;
    if (cfg.restart || (advance && col_last && row_last)) begin
      col_nxt    = '0;
      row_nxt    = '0;
      luma_nxt   = '0;
      chroma_nxt = '0;
    end else if (advance) begin
      luma_nxt   = luma_r + yv12_pkg::LUMA_W'(2);
      chroma_nxt = chroma_r + yv12_pkg::CHROMA_W'(row_r[0]);
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      luma_r   <= '0;
      chroma_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      luma_r   <= luma_nxt;
      chroma_r <= chroma_nxt;
    end
  end

  assign pos.luma   = luma_r;
  assign pos.chroma = chroma_r;
  assign pos.col    = col_r;
  assign pos.odd    = row_r[0];

`ifndef SYNTHESIS
  // Column never reaches the row length
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < pairs))
    else $error("column index beyond row length");

  // Row never reaches the frame height
  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r} < cfg.height))
    else $error("row index beyond frame height");
`endif

endmodule

`default_nettype wire

FILE: rtl/yv12_out.sv
// ---------------------------------------------------------------------------
// yv12_out
// Result stage: averages the chroma of odd rows, builds the plane
// addresses and issues the two or four byte writes of one item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yv12_out (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           item_valid,
  input  wire yv12_pkg::item_t                item,
  input  wire logic [yv12_pkg::LINE_DW-1:0]   line_data,
  input  wire logic [yv12_pkg::AREA_W-1:0]    area,
  output      logic                           item_take,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [yv12_pkg::ADDR_W-1:0]    out_write_address,
  output      logic [yv12_pkg::BYTE_W-1:0]    out_write_byte,
  output      logic [yv12_pkg::PLANE_W-1:0]   out_plane,
  output      logic                           out_last_of_item
);

  localparam logic [1:0] BEAT_Y0 = 2'd0;
  localparam logic [1:0] BEAT_Y1 = 2'd1;
  localparam logic [1:0] BEAT_V  = 2'd2;
  localparam logic [1:0] BEAT_U  = 2'd3;

  logic                          full_r,  full_nxt;
  logic [1:0]                    beat_r,  beat_nxt;
  logic                          odd_r;
  logic [yv12_pkg::LUMA_W-1:0]   luma_r;
  logic [yv12_pkg::BYTE_W-1:0]   y0_r, y1_r, av_r, au_r;
  logic [yv12_pkg::ADDR_W-1:0]   vaddr_r, uaddr_r;
  logic                          fire;
  logic                          last_beat;
  logic [yv12_pkg::BYTE_W:0]     sum_v, sum_u;
  logic [yv12_pkg::ADDR_W-1:0]   area_ext, chroma_ext;

  assign fire      = full_r && out_ready;
  assign last_beat = odd_r ? (beat_r == BEAT_U) : (beat_r == BEAT_Y1);
  assign item_take = item_valid && (!full_r || (fire && last_beat));

  // Sequence control
  always_comb begin
    full_nxt = full_r;
    beat_nxt = beat_r;
    if (item_take) begin
      full_nxt = 1'b1;
      beat_nxt = BEAT_Y0;
    end else if (fire) begin
      if (last_beat) begin
        full_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      beat_r <= BEAT_Y0;
    end else begin
      full_r <= full_nxt;
      beat_r <= beat_nxt;
    end
  end

  // Average stored and new chroma, place it in the V and U planes
  assign sum_v      = {1'b0, line_data[yv12_pkg::BYTE_W-1:0]} + {1'b0, item.v};
  assign sum_u      = {1'b0, line_data[yv12_pkg::LINE_DW-1:yv12_pkg::BYTE_W]}
                    + {1'b0, item.u};
  assign area_ext   = yv12_pkg::ADDR_W'(area);
  assign chroma_ext = yv12_pkg::ADDR_W'(item.pos.chroma);

  always_ff @(posedge clk) begin
    if (item_take) begin
      odd_r   <= item.pos.odd;
      luma_r  <= item.pos.luma;
      y0_r    <= item.y0;
      y1_r    <= item.y1;
      av_r    <= sum_v[yv12_pkg::BYTE_W:1];
      au_r    <= sum_u[yv12_pkg::BYTE_W:1];
      vaddr_r <= area_ext + chroma_ext;
      uaddr_r <= area_ext + (area_ext >> yv12_pkg::QUARTER_SHIFT) + chroma_ext;
    end
  end

  // Select the current write
  always_comb begin
    case (beat_r)
      BEAT_Y0: begin
        out_write_address = yv12_pkg::ADDR_W'(luma_r);
        out_write_byte    = y0_r;
        out_plane         = yv12_pkg::PLANE_Y;
      end
      BEAT_Y1: begin
        out_write_address = yv12_pkg::ADDR_W'({luma_r[yv12_pkg::LUMA_W-1:1], 1'b1});
        out_write_byte    = y1_r;
        out_plane         = yv12_pkg::PLANE_Y;
      end
      BEAT_V: begin
        out_write_address = vaddr_r;
        out_write_byte    = av_r;
        out_plane         = yv12_pkg::PLANE_V;
      end
      default: begin
        out_write_address = uaddr_r;
        out_write_byte    = au_r;
        out_plane         = yv12_pkg::PLANE_U;
      end
    endcase
  end

  assign out_valid        = full_r;
  assign out_last_of_item = last_beat;

`ifndef SYNTHESIS
  // Writes of one item follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !last_beat) |=> out_valid)
    else $error("item writes interrupted");
`endif

endmodule

`default_nettype wire

FILE: rtl/yuyv_to_yv12_chroma_subsample.sv
// ---------------------------------------------------------------------------
// yuyv_to_yv12_chroma_subsample
// Packed YUYV macropixels in, YV12 byte writes out.
// ---------------------------------------------------------------------------
// Each accepted macropixel yields two luma writes on even rows and two luma,
// one V and one U write on odd rows, one write per cycle on the result
// channel while out_ready is high. The single result port is what limits
// the throughput; the input side takes an item every cycle while the result
// stage has room, and the first write is offered on the result port once
// the item has passed the input register and the result stage register.
// Even-row chroma sits in a 1024-entry line store that is never cleared;
// odd rows only read entries written by the even row before them. Writing
// either dimension register restarts the frame position; write only while
// idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_yv12_chroma_subsample (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_write_enable,
  input  wire logic [yv12_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [yv12_pkg::DIM_W-1:0]     cfg_write_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [yv12_pkg::BYTE_W-1:0]    in_luma_first,
  input  wire logic [yv12_pkg::BYTE_W-1:0]    in_chroma_blue,
  input  wire logic [yv12_pkg::BYTE_W-1:0]    in_luma_second,
  input  wire logic [yv12_pkg::BYTE_W-1:0]    in_chroma_red,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [yv12_pkg::ADDR_W-1:0]    out_write_address,
  output      logic [yv12_pkg::BYTE_W-1:0]    out_write_byte,
  output      logic [yv12_pkg::PLANE_W-1:0]   out_plane,
  output      logic                           out_last_of_item
);

  yv12_pkg::cfg_t                   cfg;
  yv12_pkg::pos_t                   pos;
  yv12_pkg::item_t                  s1_r;
  logic                             s1_full_r, s1_full_nxt;
  logic                             s1_take;
  logic                             accept;
  logic [yv12_pkg::LINE_DW-1:0]     line_data;

  yv12_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .cfg              (cfg)
  );

  yv12_ctr u_ctr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (accept),
    .pos     (pos)
  );

  // Even rows store chroma, odd rows fetch it for the average
  yv12_ram #(
    .WIDTH (yv12_pkg::LINE_DW),
    .DEPTH (yv12_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && !pos.odd),
    .waddr (pos.col),
    .wdata ({in_chroma_blue, in_chroma_red}),
    .re    (accept && pos.odd),
    .raddr (pos.col),
    .rdata (line_data)
  );

  // Input register: take an item whenever it is empty or handing off
  assign in_ready = rst_n && (!s1_full_r || s1_take);
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_full_nxt = s1_full_r;
    if (accept) begin
      s1_full_nxt = 1'b1;
    end else if (s1_take) begin
      s1_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_full_r <= 1'b0;
    end else begin
      s1_full_r <= s1_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.y0  <= in_luma_first;
      s1_r.u   <= in_chroma_blue;
      s1_r.y1  <= in_luma_second;
      s1_r.v   <= in_chroma_red;
      s1_r.pos <= pos;
    end
  end

  yv12_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (s1_full_r),
    .item              (s1_r),
    .line_data         (line_data),
    .area              (cfg.area),
    .item_take         (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_plane         (out_plane),
    .out_last_of_item  (out_last_of_item)
  );

`ifndef SYNTHESIS
  // A stalled input side means the input register is holding an item
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_full_r)
    else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_yuyv_to_yv12_chroma_subsample.sv
// ---------------------------------------------------------------------------
// tb_yuyv_to_yv12_chroma_subsample
// Self-checking bench for the YUYV to YV12 chroma subsampling block.
// ---------------------------------------------------------------------------
// Macropixels go in over a valid/ready channel with random gaps. A local
// model of the frame walk predicts every Y, V and U byte write, and a
// checker compares each accepted write with the oldest prediction. Frame
// sizes cover the smallest and largest frames, clamping of out-of-range and
// odd sizes, writes to unused register indexes, restarts in mid-frame,
// frame wrap and a long receiver stall that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_yuyv_to_yv12_chroma_subsample;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned MAX_GAP         = 18;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS    = 110;
  localparam int unsigned PRINT_CAP       = 40;

  // Register indexes past the two real registers
  localparam logic [yv12_pkg::IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [yv12_pkg::IDX_W-1:0] REG_SPARE_B = 2'd3;

  // One byte write into the YV12 buffer
  typedef struct packed {
    logic [yv12_pkg::ADDR_W-1:0]  addr;
    logic [yv12_pkg::BYTE_W-1:0]  data;
    logic [yv12_pkg::PLANE_W-1:0] plane;
    logic                         last;
  } yv12_write_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_write_enable;
  logic [yv12_pkg::IDX_W-1:0]     cfg_index;
  logic [yv12_pkg::DIM_W-1:0]     cfg_write_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [yv12_pkg::BYTE_W-1:0]    in_luma_first;
  logic [yv12_pkg::BYTE_W-1:0]    in_chroma_blue;
  logic [yv12_pkg::BYTE_W-1:0]    in_luma_second;
  logic [yv12_pkg::BYTE_W-1:0]    in_chroma_red;
  logic                           out_valid;
  logic                           out_ready;
  logic [yv12_pkg::ADDR_W-1:0]    out_write_address;
  logic [yv12_pkg::BYTE_W-1:0]    out_write_byte;
  logic [yv12_pkg::PLANE_W-1:0]   out_plane;
  logic                           out_last_of_item;

  // Frame geometry and walk position as the block should hold them
  logic [yv12_pkg::DIM_W-1:0]     width_px;
  logic [yv12_pkg::DIM_W-1:0]     height_rows;
  int unsigned                    pair_col;
  int unsigned                    row_num;
  int unsigned                    luma_ptr;
  int unsigned                    chroma_ptr;
  logic [yv12_pkg::BYTE_W-1:0]    line_u_store [yv12_pkg::LINE_DEPTH];
  logic [yv12_pkg::BYTE_W-1:0]    line_v_store [yv12_pkg::LINE_DEPTH];

  yv12_write_t         pending_writes [$];

  int unsigned         items_sent;
  int unsigned         writes_checked;
  int unsigned         mismatch_count;
  int unsigned         settings_count;
  int unsigned         cycle_count;
  bit                  idle_on;
  bit                  hold_off_request;

  yuyv_to_yv12_chroma_subsample u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_index         (cfg_index),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_luma_first     (in_luma_first),
    .in_chroma_blue    (in_chroma_blue),
    .in_luma_second    (in_luma_second),
    .in_chroma_red     (in_chroma_red),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_plane         (out_plane),
    .out_last_of_item  (out_last_of_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a size to [2, maxv], then round down to even
  function automatic logic [yv12_pkg::DIM_W-1:0] clamp_dim(
      input logic [yv12_pkg::DIM_W-1:0] val, input int unsigned maxv);
    int unsigned r;
    r = val;
    if (r < 2) r = 2;
    if (r > maxv) r = maxv;
    return yv12_pkg::DIM_W'(r & 32'hFFFF_FFFE);
  endfunction

  function automatic void restart_position();
    pair_col   = 0;
    row_num    = 0;
    luma_ptr   = 0;
    chroma_ptr = 0;
  endfunction

  function automatic void apply_register(input logic [yv12_pkg::IDX_W-1:0] idx,
                                         input logic [yv12_pkg::DIM_W-1:0] val);
    case (idx)
      yv12_pkg::REG_FRAME_WIDTH: begin
        width_px = clamp_dim(val, yv12_pkg::MAX_WIDTH);
        restart_position();
      end
      yv12_pkg::REG_FRAME_HEIGHT: begin
        height_rows = clamp_dim(val, yv12_pkg::MAX_HEIGHT);
        restart_position();
      end
      default: begin
        // spare indexes leave everything as it is
      end
    endcase
  endfunction

  function automatic void add_pending_write(input int unsigned addr,
                                            input logic [yv12_pkg::BYTE_W-1:0] data,
                                            input logic [yv12_pkg::PLANE_W-1:0] plane,
                                            input logic last);
    yv12_write_t w;
    w.addr  = yv12_pkg::ADDR_W'(addr);
    w.data  = data;
    w.plane = plane;
    w.last  = last;
    pending_writes.push_back(w);
  endfunction

  // Predict the writes of one macropixel and advance the frame walk
  function automatic void predict_writes(input logic [yv12_pkg::BYTE_W-1:0] y0,
                                         input logic [yv12_pkg::BYTE_W-1:0] u,
                                         input logic [yv12_pkg::BYTE_W-1:0] y1,
                                         input logic [yv12_pkg::BYTE_W-1:0] v);
    int unsigned slot;
    int unsigned area;
    logic [yv12_pkg::BYTE_W:0] sum_u;
    logic [yv12_pkg::BYTE_W:0] sum_v;
    slot = pair_col % yv12_pkg::LINE_DEPTH;
    add_pending_write(luma_ptr, y0, yv12_pkg::PLANE_Y, 1'b0);
    if ((row_num & 1) == 0) begin
      // even row: luma only, keep chroma for the row below
      add_pending_write(luma_ptr + 1, y1, yv12_pkg::PLANE_Y, 1'b1);
      line_u_store[slot] = u;
      line_v_store[slot] = v;
    end else begin
      // odd row: average with the stored pair, V plane then U plane
      area  = int'(width_px) * int'(height_rows);
      sum_v = {1'b0, line_v_store[slot]} + {1'b0, v};
      sum_u = {1'b0, line_u_store[slot]} + {1'b0, u};
      add_pending_write(luma_ptr + 1, y1, yv12_pkg::PLANE_Y, 1'b0);
      add_pending_write(area + chroma_ptr, sum_v[yv12_pkg::BYTE_W:1],
                        yv12_pkg::PLANE_V, 1'b0);
      add_pending_write(area + area / 4 + chroma_ptr, sum_u[yv12_pkg::BYTE_W:1],
                        yv12_pkg::PLANE_U, 1'b1);
      chroma_ptr++;
    end
    luma_ptr += 2;
    pair_col++;
    if (pair_col >= width_px / 2) begin
      pair_col = 0;
      row_num++;
      if (row_num >= height_rows) restart_position();
    end
  endfunction

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] write %0d: %s got 0x%0h, wanted 0x%0h",
               $realtime, writes_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  // Send one macropixel; valid drops only when a gap is taken
  task automatic send_macropixel(input logic [yv12_pkg::BYTE_W-1:0] y0,
                                 input logic [yv12_pkg::BYTE_W-1:0] u,
                                 input logic [yv12_pkg::BYTE_W-1:0] y1,
                                 input logic [yv12_pkg::BYTE_W-1:0] v,
                                 input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma_first  <= y0;
    in_chroma_blue <= u;
    in_luma_second <= y1;
    in_chroma_red  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_writes(y0, u, y1, v);
    items_sent++;
  endtask

  task automatic send_random(input int unsigned gap);
    send_macropixel(yv12_pkg::BYTE_W'($urandom), yv12_pkg::BYTE_W'($urandom),
                    yv12_pkg::BYTE_W'($urandom), yv12_pkg::BYTE_W'($urandom), gap);
  endtask

  // Hold the input until every predicted write has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [yv12_pkg::IDX_W-1:0] idx,
                                input logic [yv12_pkg::DIM_W-1:0] val);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_write_data   <= val;
    @(posedge clk);
    apply_register(idx, val);
    settings_count++;
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [yv12_pkg::DIM_W-1:0] w,
                           input logic [yv12_pkg::DIM_W-1:0] h);
    write_register(yv12_pkg::REG_FRAME_WIDTH, w);
    write_register(yv12_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // Reset sizes of 640x480: first row luma only
  task automatic test_reset_defaults();
    idle_on = 1'b0;
    send_macropixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    wait_drained();
  endtask

  // 2x2 frame: one macropixel per row, wraps every second item
  task automatic test_smallest_frame();
    idle_on = 1'b0;
    set_frame(12'd2, 12'd2);
    send_macropixel(8'h00, 8'hFF, 8'hFF, 8'h00, 0);
    send_macropixel(8'hFF, 8'h00, 8'h00, 8'hFF, 0);
    send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1);
    send_macropixel(8'hFF, 8'hFF, 8'h00, 8'h01, 0);
    wait_drained();
  endtask

  // Sizes below the minimum, odd sizes and zero
  task automatic test_dimension_clamp();
    int unsigned k;
    idle_on = 1'b1;
    set_frame(12'd0, 12'd3);
    for (k = 0; k < 2; k++) send_random(draw_gap());
    wait_drained();
    set_frame(12'd1, 12'd0);
    for (k = 0; k < 2; k++) send_random(draw_gap());
    wait_drained();
    set_frame(12'd7, 12'd1);
    for (k = 0; k < 6; k++) send_random(draw_gap());
    wait_drained();
  endtask

  // Spare register indexes must not restart the frame
  task automatic test_spare_index();
    int unsigned k;
    idle_on = 1'b0;
    set_frame(12'd4, 12'd2);
    send_random(0);
    wait_drained();
    write_register(REG_SPARE_A, 12'hFFF);
    write_register(REG_SPARE_B, 12'h000);
    for (k = 0; k < 3; k++) send_random(0);
    wait_drained();
  endtask

  // A size write in mid-frame sends the walk back to the frame start
  task automatic test_restart_midframe();
    int unsigned k;
    idle_on = 1'b1;
    set_frame(12'd4, 12'd4);
    for (k = 0; k < 3; k++) send_random(draw_gap());
    wait_drained();
    write_register(yv12_pkg::REG_FRAME_HEIGHT, 12'd4);
    for (k = 0; k < 3; k++) send_random(draw_gap());
    wait_drained();
  endtask

  // Oversized writes saturate to 2048x2048, then a narrow frame of full
  // height puts the chroma planes behind the tallest luma plane
  task automatic test_largest_frame();
    int unsigned k;
    idle_on = 1'b1;
    set_frame(12'hFFF, 12'h801);
    for (k = 0; k < 4; k++) send_random(draw_gap());
    wait_drained();
    set_frame(12'd4, 12'hFFF);
    for (k = 0; k < 6; k++) send_random(draw_gap());
    wait_drained();
  endtask

  // Long receiver stall with the sender pushing, then random gaps on both sides
  task automatic test_backpressure();
    int unsigned k;
    idle_on = 1'b0;
    set_frame(12'd8, 12'd4);
    hold_off_request = 1'b1;
    for (k = 0; k < 24; k++) send_random(0);
    wait_drained();
    idle_on = 1'b1;
    for (k = 0; k < 8; k++) send_random(draw_gap());
    wait_drained();
  endtask

  // Random small frames, mostly whole frames, some cut off by a restart
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned k;
    int unsigned per_frame;
    logic [yv12_pkg::DIM_W-1:0] w_raw;
    logic [yv12_pkg::DIM_W-1:0] h_raw;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 7) == 0) w_raw = yv12_pkg::DIM_W'($urandom);
      else w_raw = yv12_pkg::DIM_W'(2 * $urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) h_raw = yv12_pkg::DIM_W'($urandom);
      else h_raw = yv12_pkg::DIM_W'(2 * $urandom_range(1, 4));
      if ($urandom_range(0, 1) == 0) begin
        set_frame(w_raw, h_raw);
      end else begin
        write_register(yv12_pkg::REG_FRAME_HEIGHT, h_raw);
        write_register(yv12_pkg::REG_FRAME_WIDTH, w_raw);
      end
      idle_on   = ($urandom_range(0, 3) != 0);
      per_frame = (int'(clamp_dim(w_raw, yv12_pkg::MAX_WIDTH)) / 2) *
                  int'(clamp_dim(h_raw, yv12_pkg::MAX_HEIGHT));
      if (per_frame <= 64) n = per_frame * $urandom_range(1, 2) + $urandom_range(0, 3);
      else n = $urandom_range(1, 12);
      // keep the total item count on budget
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      for (k = 0; k < n; k++) send_random(draw_gap());
      sent += n;
    end
    wait_drained();
  endtask

  // Result side: random stall before each write, long hold on request
  initial begin : result_side
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare every accepted write with the oldest prediction
  always @(posedge clk) begin : check_writes
    yv12_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unpredicted write, address", out_write_address, 0);
      end else begin
        want = pending_writes.pop_front();
        if (out_write_address !== want.addr)
          report_mismatch("address", out_write_address, want.addr);
        if (out_write_byte !== want.data)
          report_mismatch("byte", out_write_byte, want.data);
        if (out_plane !== want.plane)
          report_mismatch("plane", out_plane, want.plane);
        if (out_last_of_item !== want.last)
          report_mismatch("last flag", out_last_of_item, want.last);
      end
      writes_checked++;
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d writes outstanding",
             cycle_count, pending_writes.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= yv12_pkg::REG_FRAME_WIDTH;
    cfg_write_data   <= '0;
    in_valid         <= 1'b0;
    in_luma_first    <= '0;
    in_chroma_blue   <= '0;
    in_luma_second   <= '0;
    in_chroma_red    <= '0;
    items_sent       = 0;
    writes_checked   = 0;
    mismatch_count   = 0;
    settings_count   = 0;
    idle_on          = 1'b0;
    hold_off_request = 1'b0;
    width_px         = clamp_dim(12'd640, yv12_pkg::MAX_WIDTH);
    height_rows      = clamp_dim(12'd480, yv12_pkg::MAX_HEIGHT);
    restart_position();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_smallest_frame();
    test_dimension_clamp();
    test_spare_index();
    test_restart_midframe();
    test_largest_frame();
    test_backpressure();
    test_random_frames();

    wait_drained();
    $display("Ran %0d macropixels and checked %0d byte writes over %0d register writes,",
             items_sent, writes_checked, settings_count);
    $display("from 2x2 to 2048x2048 frames, with clamped sizes, restarts and stalls.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
